[design/tes_pkg.sv]
// Package for the text encoding sniffer: payload types, codes and sizing constants.
`timescale 1ns / 1ps

package tes_pkg;

  localparam int unsigned MAX_BYTES = 1048576;
  // byte count must hold MAX_BYTES itself; word counts hold half of it
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int WRD_W = CNT_W - 1;
  localparam int HEAD_N = 3;

  localparam logic [7:0] UTF8_BOM_0 = 8'hEF;
  localparam logic [7:0] UTF8_BOM_1 = 8'hBB;
  localparam logic [7:0] UTF8_BOM_2 = 8'hBF;
  localparam logic [7:0] UCS2_BOM_FF = 8'hFF;
  localparam logic [7:0] UCS2_BOM_FE = 8'hFE;

  typedef enum logic [2:0] {
    ENC_NONE = 3'd0,
    ENC_UTF8 = 3'd1,
    ENC_LE   = 3'd2,
    ENC_BE   = 3'd3,
    ENC_HINT = 3'd4
  } enc_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tes_in_t;

  typedef struct packed {
    enc_t encoding;
    logic has_bom;
    logic overflow;
  } tes_out_t;

endpackage

[design/text_encoding_sniffer.sv]
// Text encoding sniffer: byte stream in, one encoding verdict per buffer out.
//
//   channel | direction | handshake              | payload
//   in      | in        | in_valid / in_stall    | in_data   (tes_in_t)
//   out     | out       | out_valid / out_stall  | out_data  (tes_out_t)
//   cfg     | in        | cfg_wr_en              | cfg_wr_data (hint present)
//
// One byte is taken per cycle while in_stall is low; a byte passes the input
// register, then the counter update and verdict logic, and its verdict (last byte
// only) lands in the output register, held there until the receiver takes it.
// Only a last byte waits on out_stall, so the input stalls only while a verdict
// is held and the next verdict is ready.
// Synchronous reset clears the buffer state, the hint and both valid flags.
`timescale 1ns / 1ps

module text_encoding_sniffer
  import tes_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tes_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tes_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  logic             in_valid_r;
  tes_in_t          in_data_r;
  logic             out_valid_r;
  tes_out_t         out_data_r;
  logic             hint_r;

  logic [7:0]       head_r [HEAD_N];
  logic [7:0]       pend_r;
  logic [CNT_W-1:0] byte_cnt_r;
  logic [WRD_W-1:0] low_le_r;
  logic [WRD_W-1:0] low_be_r;
  logic             too_long_r;

  logic [7:0]       head_nxt [HEAD_N];
  logic [7:0]       pend_nxt;
  logic [CNT_W-1:0] byte_cnt_nxt;
  logic [WRD_W-1:0] low_le_nxt;
  logic [WRD_W-1:0] low_be_nxt;
  logic             too_long_nxt;
  tes_out_t         verdict_nxt;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && (!in_data_r.last_byte || out_free);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // state after this byte, and the verdict it gives
  always_comb begin
    logic [7:0]       b;
    logic [WRD_W-1:0] words;
    logic [WRD_W+2:0] le_x5;
    logic [WRD_W+2:0] be_x5;
    logic [WRD_W+2:0] w_x4;
    logic             utf8_bom;

    b = in_data_r.data_byte;
    for (int i = 0; i < HEAD_N; i++) head_nxt[i] = head_r[i];
    pend_nxt     = pend_r;
    byte_cnt_nxt = byte_cnt_r;
    low_le_nxt   = low_le_r;
    low_be_nxt   = low_be_r;
    too_long_nxt = too_long_r;

    if (too_long_r || byte_cnt_r >= CNT_W'(MAX_BYTES)) begin
      too_long_nxt = 1'b1;
    end else begin
      for (int i = 0; i < HEAD_N; i++) begin
        if (byte_cnt_r == CNT_W'(i)) head_nxt[i] = b;
      end
      if (!byte_cnt_r[0]) begin
        pend_nxt = b;
      end else begin
        if (b == 8'd0 && !pend_r[7]) low_le_nxt = low_le_r + WRD_W'(1);
        if (pend_r == 8'd0 && !b[7]) low_be_nxt = low_be_r + WRD_W'(1);
      end
      byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
    end

    // low > floor(words*8/10)  <=>  5*low > 4*words
    words = byte_cnt_nxt[CNT_W-1:1];
    le_x5 = {3'b000, low_le_nxt} + {1'b0, low_le_nxt, 2'b00};
    be_x5 = {3'b000, low_be_nxt} + {1'b0, low_be_nxt, 2'b00};
    w_x4  = {1'b0, words, 2'b00};
    utf8_bom = byte_cnt_nxt >= CNT_W'(3) && head_nxt[0] == UTF8_BOM_0 &&
               head_nxt[1] == UTF8_BOM_1 && head_nxt[2] == UTF8_BOM_2;

    verdict_nxt.encoding = ENC_NONE;
    verdict_nxt.has_bom  = 1'b0;
    verdict_nxt.overflow = 1'b0;
    if (too_long_nxt) begin
      verdict_nxt.overflow = 1'b1;
    end else if (utf8_bom) begin
      verdict_nxt.encoding = ENC_UTF8;
      verdict_nxt.has_bom  = 1'b1;
    end else if (byte_cnt_nxt < CNT_W'(2) || byte_cnt_nxt[0]) begin
      verdict_nxt.encoding = ENC_NONE;
    end else if (head_nxt[0] == UCS2_BOM_FF && head_nxt[1] == UCS2_BOM_FE) begin
      verdict_nxt.encoding = ENC_LE;
      verdict_nxt.has_bom  = 1'b1;
    end else if (head_nxt[0] == UCS2_BOM_FE && head_nxt[1] == UCS2_BOM_FF) begin
      verdict_nxt.encoding = ENC_BE;
      verdict_nxt.has_bom  = 1'b1;
    end else if (hint_r) begin
      verdict_nxt.encoding = ENC_HINT;
    end else if (le_x5 > w_x4) begin
      verdict_nxt.encoding = ENC_LE;
    end else if (be_x5 > w_x4) begin
      verdict_nxt.encoding = ENC_BE;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_data_r <= in_data;
  end

  // buffer state: advance on each byte, clear after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HEAD_N; i++) head_r[i] <= 8'd0;
      pend_r     <= 8'd0;
      byte_cnt_r <= '0;
      low_le_r   <= '0;
      low_be_r   <= '0;
      too_long_r <= 1'b0;
    end else if (advance) begin
      if (in_data_r.last_byte) begin
        for (int i = 0; i < HEAD_N; i++) head_r[i] <= 8'd0;
        pend_r     <= 8'd0;
        byte_cnt_r <= '0;
        low_le_r   <= '0;
        low_be_r   <= '0;
        too_long_r <= 1'b0;
      end else begin
        for (int i = 0; i < HEAD_N; i++) head_r[i] <= head_nxt[i];
        pend_r     <= pend_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        low_le_r   <= low_le_nxt;
        low_be_r   <= low_be_nxt;
        too_long_r <= too_long_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_r <= 1'b0;
    end else if (cfg_wr_en) begin
      hint_r <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && in_data_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_data_r.last_byte) out_data_r <= verdict_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_W'(MAX_BYTES))
    else $error("byte count beyond limit");

  a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
    too_long_r |-> byte_cnt_r == CNT_W'(MAX_BYTES))
    else $error("overflow flagged before the count filled");

  a_words_bound: assert property (@(posedge clk) disable iff (!rst_n)
    low_le_r <= byte_cnt_r[CNT_W-1:1] && low_be_r <= byte_cnt_r[CNT_W-1:1])
    else $error("low word count exceeds word count");

  a_stall_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && in_data_r.last_byte && out_valid_r && out_stall)
    else $error("input stalled without a blocked verdict");

  a_overflow_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overflow |->
      out_data_r.encoding == ENC_NONE && !out_data_r.has_bom)
    else $error("overflow verdict carries an encoding");

endmodule

[tb/tb_text_encoding_sniffer.sv]
// Self-checking testbench for the text encoding sniffer: byte buffers in, verdicts checked.
`timescale 1ns / 1ps

module tb_text_encoding_sniffer;
  import tes_pkg::*;

  localparam logic [7:0] ASCII_LIMIT = 8'd128;
  localparam int BYTES_PER_PHASE = 200;
  localparam int PHASES = 8;

  typedef logic [7:0] byte_q_t [$];

  class encoding_tracker;
    logic [7:0]       head [HEAD_N];
    logic [7:0]       pending;
    logic [CNT_W-1:0] byte_cnt;
    logic [WRD_W-1:0] low_le;
    logic [WRD_W-1:0] low_be;
    bit               too_long;
    bit               hint;
    tes_out_t         due_verdicts [$];
    int               bad_verdicts;

    function new();
      clear();
      hint = 1'b0;
      bad_verdicts = 0;
    endfunction

    function void clear();
      foreach (head[i]) head[i] = 8'h00;
      pending = 8'h00;
      byte_cnt = '0;
      low_le = '0;
      low_be = '0;
      too_long = 1'b0;
    endfunction

    function tes_out_t judge();
      tes_out_t v;
      int unsigned words;
      int unsigned cap;
      v.encoding = ENC_NONE;
      v.has_bom = 1'b0;
      v.overflow = 1'b0;
      words = byte_cnt / 2;
      // more than 80 % of the words must be low
      cap = (words * 8) / 10;
      if (too_long) begin
        v.overflow = 1'b1;
      end else if (byte_cnt >= 3 && head[0] == UTF8_BOM_0 && head[1] == UTF8_BOM_1 &&
                   head[2] == UTF8_BOM_2) begin
        v.encoding = ENC_UTF8;
        v.has_bom = 1'b1;
      end else if (byte_cnt < 2 || byte_cnt[0]) begin
        v.encoding = ENC_NONE;
      end else if (head[0] == UCS2_BOM_FF && head[1] == UCS2_BOM_FE) begin
        v.encoding = ENC_LE;
        v.has_bom = 1'b1;
      end else if (head[0] == UCS2_BOM_FE && head[1] == UCS2_BOM_FF) begin
        v.encoding = ENC_BE;
        v.has_bom = 1'b1;
      end else if (hint) begin
        v.encoding = ENC_HINT;
      end else if (low_le > cap) begin
        v.encoding = ENC_LE;
      end else if (low_be > cap) begin
        v.encoding = ENC_BE;
      end
      return v;
    endfunction

    function void take_byte(tes_in_t beat);
      if (too_long || byte_cnt >= MAX_BYTES) begin
        too_long = 1'b1;
      end else begin
        if (byte_cnt < HEAD_N) head[byte_cnt] = beat.data_byte;
        if (!byte_cnt[0]) begin
          pending = beat.data_byte;
        end else begin
          if (beat.data_byte == 8'h00 && pending < ASCII_LIMIT) low_le++;
          if (pending == 8'h00 && beat.data_byte < ASCII_LIMIT) low_be++;
        end
        byte_cnt++;
      end
      if (beat.last_byte) begin
        due_verdicts.push_back(judge());
        clear();
      end
    endfunction

    function void check_verdict(tes_out_t got);
      tes_out_t want;
      if (due_verdicts.size() == 0) begin
        bad_verdicts++;
        if (bad_verdicts <= 10)
          $display("%0t: verdict with none due: enc=%0d bom=%0b ovf=%0b", $realtime,
                   got.encoding, got.has_bom, got.overflow);
        return;
      end
      want = due_verdicts.pop_front();
      if (got.encoding != want.encoding || got.has_bom != want.has_bom ||
          got.overflow != want.overflow) begin
        bad_verdicts++;
        if (bad_verdicts <= 10)
          $display({"%0t: verdict mismatch: expected enc=%0d bom=%0b ovf=%0b,",
                    " got enc=%0d bom=%0b ovf=%0b"},
                   $realtime, want.encoding, want.has_bom, want.overflow,
                   got.encoding, got.has_bom, got.overflow);
      end
    endfunction

    function bit busy();
      return due_verdicts.size() != 0;
    endfunction

    function void close_out();
      if (due_verdicts.size() != 0) begin
        $display("%0d verdicts never delivered", due_verdicts.size());
        bad_verdicts += due_verdicts.size();
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tes_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tes_out_t out_data;
  logic     cfg_wr_en;
  logic     cfg_wr_data;

  encoding_tracker tracker = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  text_encoding_sniffer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_verdict(out_data);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input tes_in_t beat);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = beat;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(beat);
    @(negedge clk);
  endtask

  task automatic send_buffer(input byte_q_t bytes);
    tes_in_t beat;
    foreach (bytes[i]) begin
      beat.data_byte = bytes[i];
      beat.last_byte = (i == bytes.size() - 1);
      send_beat(beat);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.busy()) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hint(input logic val);
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    tracker.hint = val;
  endtask

  // change at a rising edge so the receiver never races the update
  task automatic set_phase(input int idle, input int stall, input int hold);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    hold_left = hold;
    @(negedge clk);
  endtask

  function automatic byte_q_t random_buffer();
    byte_q_t b;
    int kind;
    int nw;
    int low_pct;
    bit le_side;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = $urandom_range(0, 9);
    case (kind)
      0: b = '{UTF8_BOM_0, UTF8_BOM_1, UTF8_BOM_2};
      1: b = '{UCS2_BOM_FF, UCS2_BOM_FE};
      2: b = '{UCS2_BOM_FE, UCS2_BOM_FF};
      default: b = {};
    endcase
    if (kind == 9) begin
      // noise
      repeat ($urandom_range(1, 12)) b.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0: b.push_back(8'h00);
          1: b.push_back(8'h7F);
          2: b.push_back(8'h80);
          3: b.push_back(UCS2_BOM_FF);
          4: b.push_back(UCS2_BOM_FE);
          default: b.push_back(UTF8_BOM_0);
        endcase
      end
    end else begin
      nw = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      low_pct = $urandom_range(40, 100);
      le_side = 1'($urandom_range(0, 1));
      repeat (nw) begin
        if ($urandom_range(0, 99) < low_pct) begin
          lo = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, ASCII_LIMIT - 1));
          hi = 8'h00;
          if (!le_side) begin
            hi = lo;
            lo = 8'h00;
          end
        end else begin
          lo = 8'($urandom_range(0, 255));
          hi = 8'($urandom_range(0, 255));
        end
        b.push_back(lo);
        b.push_back(hi);
      end
    end
    if (b.size() > 1 && $urandom_range(0, 4) == 0) void'(b.pop_back());
    if (b.size() == 0) b.push_back(8'($urandom_range(0, 255)));
    return b;
  endfunction

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    int phase_bytes;
    byte_q_t buf_q;
    idle_tab = '{0, 45, 0, 36};
    stall_tab = '{0, 0, 45, 36};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_hint(1'b0);
    send_buffer('{UTF8_BOM_0, UTF8_BOM_1, UTF8_BOM_2});
    send_buffer('{UTF8_BOM_0, UTF8_BOM_1});
    send_buffer('{UCS2_BOM_FF, UCS2_BOM_FE});
    send_buffer('{UCS2_BOM_FE, UCS2_BOM_FF, 8'h00, 8'h41});
    send_buffer('{8'h41, 8'h00, 8'h7F, 8'h00});
    send_buffer('{8'h00, 8'h41});
    send_buffer('{8'h00, 8'h00});
    send_buffer('{8'h80, 8'h00});
    send_buffer('{8'hFF});
    wait_idle();
    write_hint(1'b1);
    send_buffer('{8'h41, 8'h00});
    send_buffer('{UCS2_BOM_FE, UCS2_BOM_FF});

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_hint(p % 3 == 1);
      // one phase holds the receiver off long enough to back the input up
      set_phase(idle_tab[p % 4], stall_tab[p % 4], (p == 4) ? 300 : 0);
      phase_bytes = 0;
      while (phase_bytes < BYTES_PER_PHASE) begin
        buf_q = random_buffer();
        send_buffer(buf_q);
        phase_bytes += buf_q.size();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    tracker.close_out();
    if (tracker.bad_verdicts == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/tes_pkg.sv
design/text_encoding_sniffer.sv
tb/tb_text_encoding_sniffer.sv
